// File: rtl/fds6_pkg.sv
// ----------------------------------------------------------------------------
// fds6_pkg: shared definitions of the sixth-order first-derivative stencil
// Widths, register indexes, stencil coefficients and the job record that the
// front end hands to the arithmetic back end.
// ----------------------------------------------------------------------------
package fds6_pkg;

  localparam int unsigned MAX_POINTS   = 4096;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned MIN_POINTS   = 7;

  localparam int unsigned GRID_W      = 13;
  localparam int unsigned INV_W       = 32;
  localparam int unsigned DERIV_W     = 32;
  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_POINTS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_DX      = CFG_INDEX_W'(1);

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);
  localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(65536);

  localparam int unsigned TAPS        = 7;
  localparam int unsigned NUM_KINDS   = 7;
  localparam int unsigned COEF_W      = 11;
  localparam int unsigned QUEUE_DEPTH = 8;

  // Scale-out: result = round(S60 * inv_dx / (15 * 2^18)).
  localparam int unsigned ROUND_HALF   = 1966080;
  localparam int unsigned ROUND_SHIFT  = 18;
  localparam int unsigned DIV_BY       = 15;
  localparam int unsigned RECIP_SHIFT  = 40;
  localparam int unsigned RECIP_TERMS  = RECIP_SHIFT / 4;

  localparam logic [DERIV_W:0] LIMIT_POS = (DERIV_W + 1)'((64'd1 << (DERIV_W - 1)) - 64'd1);
  localparam logic [DERIV_W:0] LIMIT_NEG = (DERIV_W + 1)'(64'd1 << (DERIV_W - 1));

  typedef enum logic [2:0] {
    KIND_EDGE0,
    KIND_EDGE1,
    KIND_EDGE2,
    KIND_MID,
    KIND_MIRROR2,
    KIND_MIRROR1,
    KIND_MIRROR0
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [INDEX_W-1:0] index;
    logic               last;
  } job_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Coefficients scaled by 60, indexed by kind and then by window tap (oldest first).
  // The mirrored rows are the one-sided rows reversed and negated.
  localparam coef_t COEF_TABLE [NUM_KINDS][TAPS] = '{
    '{-11'sd147,  11'sd360, -11'sd450,  11'sd400, -11'sd225,  11'sd72,  -11'sd10 },
    '{-11'sd10,  -11'sd77,   11'sd150, -11'sd100,  11'sd50,  -11'sd15,   11'sd2  },
    '{ 11'sd2,   -11'sd24,  -11'sd35,   11'sd80,  -11'sd30,   11'sd8,   -11'sd1  },
    '{-11'sd1,    11'sd9,   -11'sd45,   11'sd0,    11'sd45,  -11'sd9,    11'sd1  },
    '{ 11'sd1,   -11'sd8,    11'sd30,  -11'sd80,   11'sd35,   11'sd24,  -11'sd2  },
    '{-11'sd2,    11'sd15,  -11'sd50,   11'sd100, -11'sd150,  11'sd77,   11'sd10 },
    '{ 11'sd10,  -11'sd72,   11'sd225, -11'sd400,  11'sd450, -11'sd360,  11'sd147}
  };

endpackage

// File: rtl/fds6_fifo.sv
// ----------------------------------------------------------------------------
// fds6_fifo: job queue between front end and back end
// A small register-based first-in first-out queue that absorbs the bursts
// of boundary jobs so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fds6_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("Item pushed into a full job queue.");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("Item popped from an empty job queue.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Job queue fill count exceeds its depth.");

endmodule

// File: rtl/fds6_front.sv
// ----------------------------------------------------------------------------
// fds6_front: sample intake and job classification
// Keeps the seven-sample window and the sample count of the current line and
// turns every accepted sample into the stencil jobs that it causes.
// ----------------------------------------------------------------------------
module fds6_front #(
  parameter int unsigned MaxPoints   = fds6_pkg::MAX_POINTS,
  parameter int unsigned SampleWidth = fds6_pkg::SAMPLE_WIDTH
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          sample_valid_i,
  input  logic [SampleWidth-1:0]                        sample_i,
  output logic                                          sample_stall_o,
  input  logic [fds6_pkg::GRID_W-1:0]                   grid_points_i,
  input  logic                                          full_i,
  output logic                                          push_o,
  output fds6_pkg::job_t                                job_o,
  output logic [fds6_pkg::TAPS-1:0][SampleWidth-1:0]    window_o
);

  localparam int unsigned CntW = $clog2(MaxPoints);
  localparam int unsigned NW   = CntW + 1;
  localparam int unsigned CmpW = (NW > fds6_pkg::GRID_W) ? NW : fds6_pkg::GRID_W;

  logic [fds6_pkg::TAPS-1:0][SampleWidth-1:0] window_q, window_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  busy_q, busy_d;
  fds6_pkg::kind_e       pos_q, pos_d;
  fds6_pkg::kind_e       stop_q, stop_d;
  logic [NW-1:0]         mid_q, mid_d;
  logic [NW-1:0]         n_q, n_d;

  logic                  accept;
  logic [CmpW-1:0]       gp_ext;
  logic [NW-1:0]         n_clamp;
  logic [NW-1:0]         k_ext;
  logic                  final_line;
  logic                  has_jobs;
  fds6_pkg::kind_e       start_kind;
  fds6_pkg::kind_e       stop_kind;
  logic [NW-1:0]         mid_idx;
  fds6_pkg::kind_e       pos_sel;
  logic [NW-1:0]         mid_sel;
  logic [NW-1:0]         n_sel;
  logic [NW-1:0]         idx_full;

  assign sample_stall_o = busy_q || full_i;
  assign accept         = sample_valid_i && !sample_stall_o;

  always_comb begin
    gp_ext = CmpW'(grid_points_i);
    if (gp_ext < CmpW'(fds6_pkg::MIN_POINTS)) begin
      n_clamp = NW'(fds6_pkg::MIN_POINTS);
    end else if (gp_ext > CmpW'(MaxPoints)) begin
      n_clamp = NW'(MaxPoints);
    end else begin
      n_clamp = NW'(gp_ext);
    end
  end

  assign k_ext      = NW'(count_q);
  assign final_line = (k_ext + 1'b1) >= n_clamp;
  assign has_jobs   = (count_q >= CntW'(6));
  assign start_kind = (count_q == CntW'(6)) ? fds6_pkg::KIND_EDGE0 : fds6_pkg::KIND_MID;
  assign stop_kind  = final_line ? fds6_pkg::KIND_MIRROR0 : fds6_pkg::KIND_MID;
  assign mid_idx    = final_line ? (n_clamp - NW'(4)) : (k_ext - NW'(3));

  always_comb begin
    window_d = window_q;
    count_d  = count_q;
    busy_d   = busy_q;
    pos_d    = pos_q;
    stop_d   = stop_q;
    mid_d    = mid_q;
    n_d      = n_q;
    if (accept) begin
      window_d = {sample_i, window_q[fds6_pkg::TAPS-1:1]};
      count_d  = final_line ? '0 : count_q + 1'b1;
      if (has_jobs && (start_kind != stop_kind)) begin
        busy_d = 1'b1;
        pos_d  = fds6_pkg::kind_e'(start_kind + 3'd1);
        stop_d = stop_kind;
        mid_d  = mid_idx;
        n_d    = n_clamp;
      end
    end else if (busy_q && !full_i) begin
      if (pos_q == stop_q) begin
        busy_d = 1'b0;
      end else begin
        pos_d = fds6_pkg::kind_e'(pos_q + 3'd1);
      end
    end
  end

  assign pos_sel  = busy_q ? pos_q : start_kind;
  assign mid_sel  = busy_q ? mid_q : mid_idx;
  assign n_sel    = busy_q ? n_q : n_clamp;
  assign window_o = busy_q ? window_q : window_d;
  assign push_o   = busy_q ? !full_i : (accept && has_jobs);

  always_comb begin
    case (pos_sel)
      fds6_pkg::KIND_EDGE0:   idx_full = NW'(0);
      fds6_pkg::KIND_EDGE1:   idx_full = NW'(1);
      fds6_pkg::KIND_EDGE2:   idx_full = NW'(2);
      fds6_pkg::KIND_MID:     idx_full = mid_sel;
      fds6_pkg::KIND_MIRROR2: idx_full = n_sel - NW'(3);
      fds6_pkg::KIND_MIRROR1: idx_full = n_sel - NW'(2);
      fds6_pkg::KIND_MIRROR0: idx_full = n_sel - NW'(1);
      default:                idx_full = '0;
    endcase
  end

  assign job_o.kind  = pos_sel;
  assign job_o.index = fds6_pkg::INDEX_W'(idx_full);
  assign job_o.last  = (pos_sel == fds6_pkg::KIND_MIRROR0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
      busy_q   <= 1'b0;
      pos_q    <= fds6_pkg::KIND_EDGE0;
      stop_q   <= fds6_pkg::KIND_EDGE0;
      mid_q    <= '0;
      n_q      <= '0;
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
      busy_q   <= busy_d;
      pos_q    <= pos_d;
      stop_q   <= stop_d;
      mid_q    <= mid_d;
      n_q      <= n_d;
    end
  end

  a_line_start_bursts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (count_q == CntW'(6)) |=> busy_q)
    else $error("Seventh sample of a line did not start a boundary burst.");

  a_last_job_restarts_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.last |=> (count_q == '0))
    else $error("Final job of a line pushed while the sample count is not cleared.");

endmodule

// File: rtl/fds6_back.sv
// ----------------------------------------------------------------------------
// fds6_back: stencil arithmetic pipeline
// Forms the scaled stencil sum of a job, multiplies it by inv_dx, rounds to
// nearest with ties away from zero, saturates and holds the result item.
// ----------------------------------------------------------------------------
module fds6_back #(
  parameter int unsigned SampleWidth = fds6_pkg::SAMPLE_WIDTH
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [fds6_pkg::INV_W-1:0]                 inv_dx_i,
  input  logic                                       empty_i,
  output logic                                       pop_o,
  input  fds6_pkg::job_t                             job_i,
  input  logic [fds6_pkg::TAPS-1:0][SampleWidth-1:0] window_i,
  output logic                                       result_valid_o,
  input  logic                                       result_stall_i,
  output logic signed [fds6_pkg::DERIV_W-1:0]        derivative_o,
  output logic [fds6_pkg::INDEX_W-1:0]               point_index_o,
  output logic                                       last_o
);

  localparam int unsigned TAPS    = fds6_pkg::TAPS;
  localparam int unsigned DW      = fds6_pkg::DERIV_W;
  localparam int unsigned ProdW   = SampleWidth + fds6_pkg::COEF_W;
  localparam int unsigned SumW    = SampleWidth + 11;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned LoW     = MagW / 2;
  localparam int unsigned HiW     = MagW - LoW;
  localparam int unsigned PW      = MagW + fds6_pkg::INV_W;
  localparam int unsigned XW      = PW + 1 - fds6_pkg::ROUND_SHIFT;
  localparam int unsigned XCutW   = DW + 4;
  localparam int unsigned QmW     = XCutW + fds6_pkg::RECIP_SHIFT;
  localparam int unsigned NStages = 6;

  logic adv;

  logic                   valid_q [NStages];
  fds6_pkg::job_t         job_q   [NStages];

  logic signed [ProdW-1:0] prod_d [TAPS];
  logic signed [ProdW-1:0] prod_q [TAPS];
  logic signed [SumW-1:0]  sum_d, sum_q;

  logic [SumW-1:0]                  mag_full;
  logic [MagW-1:0]                  mag;
  logic [LoW+fds6_pkg::INV_W-1:0]   pplo_d, pplo_q;
  logic [HiW-1:0]                   hi_q;
  logic                             neg3_q, neg4_q, neg5_q, neg6_q;

  logic [HiW+fds6_pkg::INV_W-1:0]   hiprod;
  logic [PW-1:0]                    p_d, p_q;

  logic [PW:0]                      rounded;
  logic [XW-1:0]                    x;
  logic                             sat5_q, sat6_q;
  logic [XCutW-1:0]                 xcut5_q, xcut6_q;

  logic [QmW-1:0]                   qm;
  logic [DW-1:0]                    q0_q;

  logic [XCutW:0]                   rem;
  logic [DW:0]                      q;
  logic [DW:0]                      limit;
  logic [DW:0]                      mag_out;
  logic [DW-1:0]                    deriv_d;

  logic                             result_valid_q;
  logic signed [DW-1:0]             derivative_q;
  logic [fds6_pkg::INDEX_W-1:0]     point_index_q;
  logic                             last_q;

  assign adv   = !result_valid_q || !result_stall_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      prod_d[j] = $signed(window_i[j]) * fds6_pkg::COEF_TABLE[job_i.kind][j];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < TAPS; j++) begin
      sum_d = sum_d + SumW'(prod_q[j]);
    end
  end

  assign mag_full = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign mag      = mag_full[MagW-1:0];
  assign pplo_d   = mag[LoW-1:0] * inv_dx_i;

  assign hiprod = hi_q * inv_dx_i;
  assign p_d    = {hiprod, LoW'(0)} + PW'(pplo_q);

  assign rounded = (PW + 1)'(p_q) + (PW + 1)'(fds6_pkg::ROUND_HALF);
  assign x       = rounded[PW:fds6_pkg::ROUND_SHIFT];

  always_comb begin
    qm = '0;
    for (int i = 0; i < fds6_pkg::RECIP_TERMS; i++) begin
      qm = qm + (QmW'(xcut5_q) << (4 * i));
    end
  end

  always_comb begin
    rem     = (XCutW + 1)'(xcut6_q) - (((XCutW + 1)'(q0_q) << 4) - (XCutW + 1)'(q0_q));
    q       = (DW + 1)'(q0_q) + ((rem >= (XCutW + 1)'(fds6_pkg::DIV_BY)) ? 1'b1 : 1'b0);
    limit   = neg6_q ? fds6_pkg::LIMIT_NEG : fds6_pkg::LIMIT_POS;
    mag_out = (sat6_q || (q > limit)) ? limit : q;
    deriv_d = neg6_q ? (~mag_out[DW-1:0] + 1'b1) : mag_out[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStages; i++) begin
        valid_q[i] <= 1'b0;
      end
      result_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= pop_o;
      for (int i = 1; i < NStages; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
      result_valid_q <= valid_q[NStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      job_q[0] <= job_i;
      for (int i = 1; i < NStages; i++) begin
        job_q[i] <= job_q[i-1];
      end
      for (int j = 0; j < TAPS; j++) begin
        prod_q[j] <= prod_d[j];
      end
      sum_q   <= sum_d;
      pplo_q  <= pplo_d;
      hi_q    <= mag[MagW-1:LoW];
      neg3_q  <= sum_q[SumW-1];
      p_q     <= p_d;
      neg4_q  <= neg3_q;
      sat5_q  <= (x[XW-1:DW] >= (XW - DW)'(fds6_pkg::DIV_BY));
      xcut5_q <= x[XCutW-1:0];
      neg5_q  <= neg4_q;
      q0_q    <= qm[fds6_pkg::RECIP_SHIFT +: DW];
      xcut6_q <= xcut5_q;
      sat6_q  <= sat5_q;
      neg6_q  <= neg5_q;
      derivative_q  <= $signed(deriv_d);
      point_index_q <= job_q[NStages-1].index;
      last_q        <= job_q[NStages-1].last;
    end
  end

  assign result_valid_o = result_valid_q;
  assign derivative_o   = derivative_q;
  assign point_index_o  = point_index_q;
  assign last_o         = last_q;

endmodule

// File: rtl/first_derivative_stencil_6th_order.sv
// ----------------------------------------------------------------------------
// first_derivative_stencil_6th_order: streaming sixth-order first derivative
// Takes one line of grid samples at a time and returns the sixth-order
// first derivative at every grid point, with point index and last mark.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  sample    in         sample_valid_i / sample_stall_o  sample_i
//  result    out        result_valid_o / result_stall_i  derivative_o, point_index_o, last_o
//  cfg       in         cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// A sample that causes at most one result needs no burst; the seventh
// sample of a line causes four jobs and the final sample four, or seven on a
// seven-point line, and the front end pushes them one job per cycle into the
// queue while it is not full, stalling further samples meanwhile.
// Reset clears the window, the count, the queue and the pipeline at once.
// A held result stalls the arithmetic pipeline; a full queue stalls samples.
// ----------------------------------------------------------------------------
module first_derivative_stencil_6th_order #(
  parameter int unsigned MaxPoints   = fds6_pkg::MAX_POINTS,
  parameter int unsigned SampleWidth = fds6_pkg::SAMPLE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                sample_valid_i,
  input  logic signed [SampleWidth-1:0]       sample_i,
  output logic                                sample_stall_o,
  output logic                                result_valid_o,
  input  logic                                result_stall_i,
  output logic signed [fds6_pkg::DERIV_W-1:0] derivative_o,
  output logic [fds6_pkg::INDEX_W-1:0]        point_index_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fds6_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [fds6_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned QWidth = fds6_pkg::TAPS * SampleWidth + $bits(fds6_pkg::job_t);

  logic [fds6_pkg::GRID_W-1:0] grid_points_q;
  logic [fds6_pkg::INV_W-1:0]  inv_dx_q;

  logic                                       push;
  logic                                       pop;
  logic                                       full;
  logic                                       empty;
  fds6_pkg::job_t                             push_job;
  fds6_pkg::job_t                             pop_job;
  logic [fds6_pkg::TAPS-1:0][SampleWidth-1:0] push_window;
  logic [fds6_pkg::TAPS-1:0][SampleWidth-1:0] pop_window;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_points_q <= fds6_pkg::GRID_RESET;
      inv_dx_q      <= fds6_pkg::INV_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fds6_pkg::CFG_GRID_POINTS: grid_points_q <= cfg_data_i[fds6_pkg::GRID_W-1:0];
        fds6_pkg::CFG_INV_DX:      inv_dx_q      <= cfg_data_i[fds6_pkg::INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fds6_front #(
    .MaxPoints  (MaxPoints),
    .SampleWidth(SampleWidth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid_i),
    .sample_i      (sample_i),
    .sample_stall_o(sample_stall_o),
    .grid_points_i (grid_points_q),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job),
    .window_o      (push_window)
  );

  fds6_fifo #(
    .Width(QWidth),
    .Depth(fds6_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_window, push_job}),
    .pop_i  (pop),
    .rdata_o({pop_window, pop_job}),
    .full_o (full),
    .empty_o(empty)
  );

  fds6_back #(
    .SampleWidth(SampleWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .inv_dx_i      (inv_dx_q),
    .empty_i       (empty),
    .pop_o         (pop),
    .job_i         (pop_job),
    .window_i      (pop_window),
    .result_valid_o(result_valid_o),
    .result_stall_i(result_stall_i),
    .derivative_o  (derivative_o),
    .point_index_o (point_index_o),
    .last_o        (last_o)
  );

endmodule

// File: test/fds6_derivative_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fds6_derivative_checker: result checker for the sixth-order stencil
// Watches the sample, result and register channels, keeps its own copy of
// the window, the count and the registers, and predicts every derivative
// item. Each accepted result item is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module fds6_derivative_checker
  import fds6_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sample_valid_i,
  input  logic                           sample_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           result_valid_i,
  input  logic                           result_stall_i,
  input  logic signed [DERIV_W-1:0]      derivative_i,
  input  logic [INDEX_W-1:0]             point_index_i,
  input  logic                           last_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  output int                             mismatches_o,
  output int                             outstanding_o
);

  localparam longint unsigned SCALE_DEN = 3932160;
  localparam int CENTRAL_ROW = 3;

  // Rows 0 to 2 are the one-sided boundary stencils, row 3 the central one,
  // all scaled by 60 and ordered from the oldest sample.
  localparam int STENCIL_TAPS [4][7] = '{
    '{-147, 360, -450,  400, -225,  72, -10},
    '{ -10, -77,  150, -100,   50, -15,   2},
    '{   2, -24,  -35,   80,  -30,   8,  -1},
    '{  -1,   9,  -45,    0,   45,  -9,   1}
  };

  typedef struct packed {
    logic [DERIV_W-1:0] derivative;
    logic [INDEX_W-1:0] index;
    logic               last;
  } point_result_t;

  logic signed [SAMPLE_WIDTH-1:0] window [7];
  int unsigned                    line_count;
  logic [GRID_W-1:0]              grid_points;
  logic [INV_W-1:0]               inv_dx;
  point_result_t                  expected_points [$];
  int                             fail_total;

  function automatic longint stencil_sum(input int row, input bit mirrored);
    longint acc;
    int     j;
    acc = 0;
    for (j = 0; j < 7; j++) begin
      acc += longint'(STENCIL_TAPS[row][j]) * longint'(mirrored ? window[6-j] : window[j]);
    end
    return mirrored ? -acc : acc;
  endfunction

  function automatic logic [DERIV_W-1:0] scaled_derivative(input longint sum60);
    logic        negative;
    logic [63:0] magnitude;
    logic [95:0] product;
    logic [95:0] quotient;
    logic [95:0] remainder;
    logic [95:0] limit;
    negative  = sum60 < 0;
    magnitude = negative ? 64'(-sum60) : 64'(sum60);
    product   = 96'(magnitude) * 96'(inv_dx);
    quotient  = product / 96'(SCALE_DEN);
    remainder = product % 96'(SCALE_DEN);
    if (2 * remainder >= 96'(SCALE_DEN)) begin
      quotient = quotient + 1;
    end
    limit = negative ? 96'h8000_0000 : 96'h7FFF_FFFF;
    if (quotient > limit) begin
      quotient = limit;
    end
    return negative ? DERIV_W'(-quotient) : DERIV_W'(quotient);
  endfunction

  function automatic void queue_point(input longint sum60, input int unsigned index,
                                      input bit last);
    point_result_t point;
    point.derivative = scaled_derivative(sum60);
    point.index      = INDEX_W'(index);
    point.last       = last;
    expected_points.push_back(point);
  endfunction

  task automatic predict_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
    int unsigned n;
    int unsigned k;
    bit          closing;
    int          j;
    n = grid_points;
    if (n < MIN_POINTS) begin
      n = MIN_POINTS;
    end
    if (n > MAX_POINTS) begin
      n = MAX_POINTS;
    end
    k = line_count;
    for (j = 0; j < 6; j++) begin
      window[j] = window[j+1];
    end
    window[6] = value;
    closing = (k + 1 >= n);
    if (k == 6) begin
      for (j = 0; j < 3; j++) begin
        queue_point(stencil_sum(j, 1'b0), j, 1'b0);
      end
      queue_point(stencil_sum(CENTRAL_ROW, 1'b0), 3, 1'b0);
    end else if (k > 6 && !closing) begin
      queue_point(stencil_sum(CENTRAL_ROW, 1'b0), k - 3, 1'b0);
    end
    if (closing) begin
      if (k > 6) begin
        queue_point(stencil_sum(CENTRAL_ROW, 1'b0), n - 4, 1'b0);
      end
      for (j = 2; j >= 0; j--) begin
        queue_point(stencil_sum(j, 1'b1), n - 1 - j, j == 0);
      end
      line_count = 0;
    end else begin
      line_count = k + 1;
    end
  endtask

  task automatic check_result();
    point_result_t want;
    if (expected_points.size() == 0) begin
      $display("%0t: result with none expected: expected none, got derivative %0d point %0d last %0b",
               $time, derivative_i, point_index_i, last_i);
      fail_total++;
    end else begin
      want = expected_points.pop_front();
      if (want.derivative !== derivative_i) begin
        $display("%0t: derivative of point %0d: expected %0d, got %0d",
                 $time, want.index, $signed(want.derivative), derivative_i);
        fail_total++;
      end
      if (want.index !== point_index_i) begin
        $display("%0t: point index: expected %0d, got %0d", $time, want.index, point_index_i);
        fail_total++;
      end
      if (want.last !== last_i) begin
        $display("%0t: last mark of point %0d: expected %0b, got %0b",
                 $time, want.index, want.last, last_i);
        fail_total++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (window[j]) begin
        window[j] = '0;
      end
      line_count  = 0;
      grid_points = GRID_RESET;
      inv_dx      = INV_RESET;
      expected_points.delete();
      fail_total  = 0;
    end else begin
      if (result_valid_i && !result_stall_i) begin
        check_result();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_GRID_POINTS) begin
          grid_points = cfg_data_i[GRID_W-1:0];
        end else if (cfg_index_i == CFG_INV_DX) begin
          inv_dx = cfg_data_i[INV_W-1:0];
        end
      end
      if (sample_valid_i && !sample_stall_i) begin
        predict_sample(sample_i);
      end
    end
    mismatches_o  <= fail_total;
    outstanding_o <= expected_points.size();
  end

endmodule

// File: test/tb_first_derivative_stencil_6th_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_derivative_stencil_6th_order: testbench of the stencil block
// Drives lines of grid samples under several register settings, first a
// short directed set of corner cases and then random lines, with random
// gaps on the sample side and random stalls on the result side. A separate
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_first_derivative_stencil_6th_order;
  import fds6_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 375;
  localparam int unsigned IDLE_PERCENT   = 37;
  localparam int unsigned STEADY_FROM    = 150;
  localparam int unsigned STEADY_TO      = 250;

  localparam logic [SAMPLE_WIDTH-1:0] CORNER_SAMPLES [10] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
    32'h0004_0000, 32'h0009_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h5555_5555
  };

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           sample_valid_i = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] sample_i       = '0;
  logic                           sample_stall_o;
  logic                           result_valid_o;
  logic                           result_stall_i = 1'b0;
  logic signed [DERIV_W-1:0]      derivative_o;
  logic [INDEX_W-1:0]             point_index_o;
  logic                           last_o;
  logic                           cfg_valid_i    = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_INDEX_W-1:0]         cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]          cfg_data_i     = '0;

  logic steady       = 1'b0;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;

  first_derivative_stencil_6th_order dut (
    .clk_i,
    .rst_ni,
    .sample_valid_i,
    .sample_i,
    .sample_stall_o,
    .result_valid_o,
    .result_stall_i,
    .derivative_o,
    .point_index_o,
    .last_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  fds6_derivative_checker derivative_check (
    .clk_i,
    .rst_ni,
    .sample_valid_i,
    .sample_stall_i (sample_stall_o),
    .sample_i,
    .result_valid_i (result_valid_o),
    .result_stall_i,
    .derivative_i   (derivative_o),
    .point_index_i  (point_index_o),
    .last_i         (last_o),
    .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    result_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if ((sample_valid_i && !sample_stall_o) || (result_valid_o && !result_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= value;
    do @(posedge clk_i); while (sample_stall_o);
  endtask

  task automatic drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic reconfigure(input bit set_grid, input logic [GRID_W-1:0] grid,
                             input bit set_inv, input logic [INV_W-1:0] inv,
                             input bit poke_unused);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (set_grid) begin
      write_reg(CFG_GRID_POINTS, CFG_DATA_W'(grid));
    end
    if (set_inv) begin
      write_reg(CFG_INV_DX, CFG_DATA_W'(inv));
    end
    if (poke_unused) begin
      write_reg(CFG_INDEX_W'($urandom_range(CFG_INV_DX + 1, 2**CFG_INDEX_W - 1)), $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($urandom_range(0, 2**21)) - 32'(2**20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned      random_sent;
    int unsigned      grid_now;
    int unsigned      span;
    int unsigned      len;
    int unsigned      i;
    bit               set_grid;
    logic [INV_W-1:0] inv_pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, then the line is shortened so that the next sample ends it.
    for (i = 0; i < 10; i++) begin
      send_sample(CORNER_SAMPLES[i]);
    end
    reconfigure(1'b1, GRID_W'(MIN_POINTS), 1'b0, '0, 1'b0);
    send_sample(32'hAAAA_AAAA);

    // Seven-point lines: full-scale alternation saturates, then a zero scale.
    reconfigure(1'b1, GRID_W'(MIN_POINTS), 1'b1, '1, 1'b1);
    for (i = 0; i < 7; i++) begin
      send_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end
    reconfigure(1'b1, GRID_W'(3), 1'b1, '0, 1'b0);
    for (i = 0; i < 7; i++) begin
      send_sample(random_sample());
    end

    grid_now    = 3;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_grid = $urandom_range(0, 3) != 0;
      if (set_grid) begin
        case ($urandom_range(0, 9))
          0: grid_now = $urandom_range(0, MIN_POINTS - 1);
          1: grid_now = $urandom_range(MAX_POINTS + 1, 2**GRID_W - 1);
          2: grid_now = MIN_POINTS;
          default: grid_now = $urandom_range(MIN_POINTS + 1, 40);
        endcase
      end
      case ($urandom_range(0, 5))
        0: inv_pick = '0;
        1: inv_pick = INV_W'(1);
        2: inv_pick = '1;
        3: inv_pick = INV_RESET;
        default: inv_pick = $urandom;
      endcase
      reconfigure(set_grid, GRID_W'(grid_now), $urandom_range(0, 1), inv_pick,
                  $urandom_range(0, 4) == 0);
      span = grid_now < MIN_POINTS ? MIN_POINTS : grid_now;
      if (span > 64) begin
        len = $urandom_range(5, 40);
      end else begin
        len = $urandom_range(span, 3 * span);
      end
      for (i = 0; i < len && random_sent < RANDOM_ITEMS; i++) begin
        steady <= random_sent >= STEADY_FROM && random_sent < STEADY_TO;
        send_sample(random_sample());
        random_sent++;
        if (random_sent == RANDOM_ITEMS / 2) begin
          drain();
        end
      end
    end
    steady <= 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fds6_pkg.sv
rtl/fds6_fifo.sv
rtl/fds6_front.sv
rtl/fds6_back.sv
rtl/first_derivative_stencil_6th_order.sv
test/fds6_derivative_checker.sv
test/tb_first_derivative_stencil_6th_order.sv
